### sv/local_binary_pattern_3x3_unit_defines.svh
// Assertion macros shared by the 3x3 local binary pattern unit.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef LOCAL_BINARY_PATTERN_3X3_UNIT_DEFINES_SVH
`define LOCAL_BINARY_PATTERN_3X3_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define LBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbp3x3 check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted (active low).
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbp3x3 check failed: next-cycle rule");

`endif

### sv/lbp3x3_pkg.sv
// Shared types and constants of the 3x3 local binary pattern unit.
// Depends on nothing; imported by every module of the unit but lbp3x3_ram.
package lbp3x3_pkg;

    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int OUT_POS_W  = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

    // Smallest legal frame side.
    localparam int MIN_SIDE = 3;

    // Per-pixel position flags handed from the position counter to the datapath.
    typedef struct packed {
        logic interior;    // the pixel completes a full window
        logic frame_last;  // the pixel is the last one of the frame
    } t_pos_flags;

endpackage

### sv/lbp3x3_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module lbp3x3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/lbp3x3_pos.sv
// Frame size registers and raster position counters of the LBP unit.
// Depends on lbp3x3_pkg.
module lbp3x3_pos
    import lbp3x3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_advance,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_col,
    output logic [$clog2(MAX_HEIGHT)-1:0] o_row,
    output t_pos_flags                    o_flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int SZW_W = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                           $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
    localparam int SZH_W = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                           $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_image_width,  n_image_width;
    logic [CFG_DATA_W-1:0] r_image_height, n_image_height;
    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;

    logic [SZW_W-1:0] w_ext, w_eff;
    logic [SZH_W-1:0] h_ext, h_eff;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic             cfg_hit;

    // Sizes outside the legal range are clamped to it.
    always_comb begin
        w_ext = SZW_W'(r_image_width);
        h_ext = SZH_W'(r_image_height);
        if (w_ext < SZW_W'(MIN_SIDE)) begin
            w_eff = SZW_W'(MIN_SIDE);
        end else if (w_ext > SZW_W'(MAX_WIDTH)) begin
            w_eff = SZW_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext < SZH_W'(MIN_SIDE)) begin
            h_eff = SZH_W'(MIN_SIDE);
        end else if (h_ext > SZH_W'(MAX_HEIGHT)) begin
            h_eff = SZH_W'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
        last_col = COL_W'(w_eff - SZW_W'(1));
        last_row = ROW_W'(h_eff - SZH_W'(1));
    end

    always_comb begin
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        n_col          = r_col;
        n_row          = r_row;
        cfg_hit        = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    n_image_width = i_cfg_data;
                    cfg_hit       = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    n_image_height = i_cfg_data;
                    cfg_hit        = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        // A write to a known register restarts the frame.
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (i_advance) begin
            if (r_col == last_col) begin
                n_col = '0;
                n_row = (r_row == last_row) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            r_image_width  <= n_image_width;
            r_image_height <= n_image_height;
            r_col          <= n_col;
            r_row          <= n_row;
        end
    end

    assign o_col              = r_col;
    assign o_row              = r_row;
    assign o_flags.interior   = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
    assign o_flags.frame_last = (r_col == last_col) && (r_row == last_row);

endmodule

### sv/lbp3x3_win.sv
// Two-column window registers and the eight-way comparison of the LBP unit.
// Depends on lbp3x3_pkg.
module lbp3x3_win
    import lbp3x3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic [PIX_W-1:0]  i_top,
    input  logic [PIX_W-1:0]  i_mid,
    input  logic [PIX_W-1:0]  i_bot,
    output logic [CODE_W-1:0] o_code
);

    // Column c-2 (older) and column c-1 (newer); top, middle, bottom.
    logic [PIX_W-1:0] r_old_top, r_old_mid, r_old_bot;
    logic [PIX_W-1:0] r_new_top, r_new_mid, r_new_bot;

    logic [PIX_W-1:0] nb [CODE_W];
    logic [PIX_W-1:0] centre;

    always_comb begin
        centre = r_new_mid;
        nb[0]  = r_old_top;
        nb[1]  = r_new_top;
        nb[2]  = i_top;
        nb[3]  = r_old_mid;
        nb[4]  = i_mid;
        nb[5]  = r_old_bot;
        nb[6]  = r_new_bot;
        nb[7]  = i_bot;
        for (int k = 0; k < CODE_W; k++) begin
            o_code[k] = (nb[k] >= centre);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_top <= '0;
            r_old_mid <= '0;
            r_old_bot <= '0;
            r_new_top <= '0;
            r_new_mid <= '0;
            r_new_bot <= '0;
        end else if (i_shift) begin
            r_old_top <= r_new_top;
            r_old_mid <= r_new_mid;
            r_old_bot <= r_new_bot;
            r_new_top <= i_top;
            r_new_mid <= i_mid;
            r_new_bot <= i_bot;
        end
    end

endmodule

### sv/local_binary_pattern_3x3_unit.sv
// Top level of the streaming 3x3 local binary pattern unit.
// Depends on lbp3x3_pkg, lbp3x3_ram, lbp3x3_pos, lbp3x3_win and the defines header.
//
//   channel   direction  handshake                        payload
//   pixel     in         i_pixel_valid / o_pixel_ready    i_pixel
//   lbp       out        o_lbp_valid / i_lbp_ready        o_lbp_code, o_center_row,
//                                                         o_center_col, o_frame_last
//   cfg       in         i_cfg_we (no wait)               i_cfg_index, i_cfg_data
//
// One pixel is accepted per clock while o_pixel_ready is high. A pixel's line-store
// read is issued when it is accepted, and the RAM registers the data as the pixel
// enters the second stage; when a window's bottom-right pixel retires from there, its
// code is loaded into the output register and leaves it while i_lbp_ready is high.
// Reset is synchronous and active low; it restores the 640 x 480 frame size, the
// counters and the window. The line stores are not cleared: each entry is written
// in a frame before any code depends on it.
// A stalled output holds a second stage that carries a code, which in turn drops
// o_pixel_ready; a pixel that produces no code still retires while a result waits.
`include "local_binary_pattern_3x3_unit_defines.svh"

module local_binary_pattern_3x3_unit
    import lbp3x3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pixel_valid,
    output logic                  o_pixel_ready,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  o_lbp_valid,
    input  logic                  i_lbp_ready,
    output logic [CODE_W-1:0]     o_lbp_code,
    output logic [OUT_POS_W-1:0]  o_center_row,
    output logic [OUT_POS_W-1:0]  o_center_col,
    output logic                  o_frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Position of the next incoming pixel.
    logic [COL_W-1:0] pos_col;
    logic [ROW_W-1:0] pos_row;
    t_pos_flags       pos_flags;

    // Second stage: the pixel whose line-store data is now on the RAM outputs.
    logic             r_s1_valid, n_s1_valid;
    logic [PIX_W-1:0] r_s1_px;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    t_pos_flags       r_s1_flags;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    logic [CODE_W-1:0]    r_code;
    logic [OUT_POS_W-1:0] r_center_row;
    logic [OUT_POS_W-1:0] r_center_col;
    logic                 r_frame_last;

    logic             in_accept;
    logic             s1_fire;
    logic [PIX_W-1:0] top_px, mid_px;
    logic [CODE_W-1:0] code;
    logic [31:0]      row_m1, col_m1;

    lbp3x3_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (in_accept),
        .o_col       (pos_col),
        .o_row       (pos_row),
        .o_flags     (pos_flags)
    );

    // The older store feeds the window's top row, the newer store its middle row.
    // Each entry moves down one store when the pixel of its column goes by.
    lbp3x3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_older (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (mid_px),
        .i_re    (in_accept),
        .i_raddr (pos_col),
        .o_rdata (top_px)
    );

    lbp3x3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_newer (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_px),
        .i_re    (in_accept),
        .i_raddr (pos_col),
        .o_rdata (mid_px)
    );

    lbp3x3_win u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_fire),
        .i_top   (top_px),
        .i_mid   (mid_px),
        .i_bot   (r_s1_px),
        .o_code  (code)
    );

    // The second stage retires unless it carries a code and the output register
    // still holds one that is not being taken. Reads and writes of one column are
    // a whole row apart, so the read-modify-write needs no forwarding.
    assign s1_fire       = r_s1_valid &&
                           (!r_s1_flags.interior || !r_out_valid || i_lbp_ready);
    assign o_pixel_ready = !r_s1_valid || s1_fire;
    assign in_accept     = i_pixel_valid && o_pixel_ready;

    assign row_m1 = 32'(r_s1_row) - 32'd1;
    assign col_m1 = 32'(r_s1_col) - 32'd1;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_fire && r_s1_flags.interior) begin
            n_out_valid = 1'b1;
        end else if (i_lbp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_px    <= i_pixel;
            r_s1_col   <= pos_col;
            r_s1_row   <= pos_row;
            r_s1_flags <= pos_flags;
        end
        if (s1_fire && r_s1_flags.interior) begin
            r_code       <= code;
            r_center_row <= row_m1[OUT_POS_W-1:0];
            r_center_col <= col_m1[OUT_POS_W-1:0];
            r_frame_last <= r_s1_flags.frame_last;
        end
    end

    assign o_lbp_valid  = r_out_valid;
    assign o_lbp_code   = r_code;
    assign o_center_row = r_center_row;
    assign o_center_col = r_center_col;
    assign o_frame_last = r_frame_last;

    // An accepted pixel always lands in the second stage.
    `LBP_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, in_accept, r_s1_valid)
    // A retiring interior pixel always leaves a result in the output register.
    `LBP_ASSERT_NEXT(a_code_reaches_out, i_clk, i_rst_n,
                     s1_fire && r_s1_flags.interior, o_lbp_valid)
    // A held second stage keeps its column, so its write-back goes where it was read.
    `LBP_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_fire,
                     r_s1_valid && $stable(r_s1_col))
    // The line stores never see a read and a write of one column in the same cycle.
    `LBP_ASSERT_NOW(a_no_rw_collision, i_clk, i_rst_n, s1_fire && in_accept,
                    r_s1_col != pos_col)

endmodule
